FILE: hw/rtl/life_generation_stencil_top_defines.svh
// Assertion macros shared by the stencil block's checkers.
// Needs signals named clock and reset in the scope of each use.
`ifndef LIFE_GENERATION_STENCIL_TOP_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define LGS_CHECK_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define LGS_CHECK_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, checked during reset as well
`define LGS_CHECK_ANY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lgs_pkg.sv
// Shared types, constants and the B3/S23 rule for the life stencil block.
// No dependencies; compiled first.
`default_nettype none

package lgs_pkg;

   // Field widths of the channels and the register file
   localparam int CELL_W      = 1;
   localparam int ROW_OUT_W   = 10;
   localparam int COL_OUT_W   = 10;
   localparam int ROW_WIDTH_W = 11;
   localparam int INT_ROWS_W  = 10;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_W   = 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERIOR_ROWS = 1'd1;

   // Register reset values and legal floors
   localparam int ROW_WIDTH_RST = 64;
   localparam int INT_ROWS_RST  = 64;
   localparam int MIN_WIDTH     = 3;
   localparam int MIN_INT_ROWS  = 1;

   // Default geometry limits
   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;

   // First slab row and column at which a result becomes due
   localparam int FIRST_LIVE_ROW = 2;
   localparam int FIRST_LIVE_COL = 2;

   // Rule counts
   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   // Result queue sizing
   localparam int BURST_MAX       = 3;
   localparam int PUSH_W          = 2;
   localparam int RSP_QUEUE_DEPTH = 16;

   // Bit positions in a column of the three-row window
   localparam int TOP_BIT = 2;
   localparam int MID_BIT = 1;
   localparam int OLD_BIT = 0;

   typedef logic [2:0] col_vec_type;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] out_row;
      logic [COL_OUT_W-1:0] out_col;
      logic                 cell_next;
      logic                 gen_last;
   } result_type;

   // Next state of the middle cell of three window columns
   function automatic logic life_next(input col_vec_type left, input col_vec_type center,
                                      input col_vec_type right);
      logic [3:0] alive;
      alive = 4'(left[TOP_BIT]) + 4'(left[MID_BIT]) + 4'(left[OLD_BIT])
            + 4'(center[TOP_BIT]) + 4'(center[OLD_BIT])
            + 4'(right[TOP_BIT]) + 4'(right[MID_BIT]) + 4'(right[OLD_BIT]);
      return (alive == 4'(BIRTH_COUNT)) ||
             ((alive == 4'(SURVIVE_COUNT)) && center[MID_BIT]);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lgs_stream_if.sv
// Valid/ready channel interfaces for the life stencil block's cells and results.
// Depends on lgs_pkg.
`default_nettype none

interface lgs_req_if;
   import lgs_pkg::*;
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_in;
   modport source (output valid, output cell_in, input ready);
   modport sink (input valid, input cell_in, output ready);
endinterface

interface lgs_rsp_if;
   import lgs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ROW_OUT_W-1:0] out_row;
   logic [COL_OUT_W-1:0] out_col;
   logic                 cell_next;
   logic                 gen_last;
   modport source (output valid, output out_row, output out_col, output cell_next,
                   output gen_last, input ready);
   modport sink (input valid, input out_row, input out_col, input cell_next,
                 input gen_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/life_generation_stencil_top.sv
// Life stencil top level: one B3/S23 generation over a streamed slab of cells.
// Depends on lgs_pkg and the channel interfaces in lgs_stream_if.
//
// Cells enter on req_if one bit per transfer in raster order: a halo row,
// interior_rows interior rows, a halo row, row_width cells each, columns
// wrapping like a torus. Results leave on rsp_if as (out_row, out_col,
// cell_next, gen_last); gen_last marks the final cell of the slab.
// Each cell from column 2 of slab row 2 on yields one result for the cell
// up and to the left; the last cell of a row yields three.
// A result is registered in the input stage and then in the result queue before it is offered.
// Throughput: one cell per cycle while rsp_if keeps taking results; the
// 16-entry result queue absorbs the three-result burst at each row end, and
// req_if.ready drops, outside reset, only when the queue could not hold the
// results of the cell in flight plus a new one.
// A receiver stall fills the queue and then holds off req_if; no result is
// lost. Reset empties the queue, restores the registers to 64 x 64 and
// restarts the slab; any register write also restarts the slab.
// Registers (APB, write in setup + access, pready always high):
// 0x0 row_width, 0x4 interior_rows.
`default_nettype none

module life_generation_stencil_top #(
   parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   lgs_req_if.sink                         req_if,
   lgs_rsp_if.source                       rsp_if,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lgs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lgs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lgs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import lgs_pkg::*;

   localparam int COL_W        = $clog2(MAX_COLS);
   localparam int WID_W        = COL_W + 1;
   localparam int ROW_W        = $clog2(MAX_ROWS);
   localparam int Q_AW         = $clog2(RSP_QUEUE_DEPTH);
   localparam int Q_CW         = Q_AW + 1;
   localparam int Q_OPEN_IDLE  = RSP_QUEUE_DEPTH - BURST_MAX;
   localparam int Q_OPEN_BUSY  = RSP_QUEUE_DEPTH - 2 * BURST_MAX;

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [INT_ROWS_W-1:0]  interior_rows_ff;
   logic                   cfg_wr;
   logic [CSR_IDX_W-1:0]   csr_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[CSR_ADDR_W-1 -: CSR_IDX_W];

   // Write a register on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= ROW_WIDTH_W'(ROW_WIDTH_RST);
         interior_rows_ff <= INT_ROWS_W'(INT_ROWS_RST);
      end else if (cfg_wr) begin
         unique case (csr_idx)
            REG_ROW_WIDTH:     row_width_ff     <= pwdata[ROW_WIDTH_W-1:0];
            REG_INTERIOR_ROWS: interior_rows_ff <= pwdata[INT_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_idx)
         REG_ROW_WIDTH:     prdata = CSR_DATA_W'(row_width_ff);
         REG_INTERIOR_ROWS: prdata = CSR_DATA_W'(interior_rows_ff);
         default:           prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Effective geometry
   // ------------------------------------------------------------------
   logic [WID_W-1:0] eff_width;
   logic [COL_W-1:0] last_col;
   logic [ROW_W-1:0] last_row;

   // Clamp the width into its legal range
   always_comb begin
      if (row_width_ff < ROW_WIDTH_W'(MIN_WIDTH)) begin
         eff_width = WID_W'(MIN_WIDTH);
      end else if (32'(row_width_ff) > MAX_COLS) begin
         eff_width = WID_W'(MAX_COLS);
      end else begin
         eff_width = WID_W'(row_width_ff);
      end
   end
   assign last_col = COL_W'(eff_width - WID_W'(1));

   // Last slab row is the lower halo: interior rows plus one
   always_comb begin
      if (interior_rows_ff < INT_ROWS_W'(MIN_INT_ROWS)) begin
         last_row = ROW_W'(MIN_INT_ROWS + 1);
      end else if (32'(interior_rows_ff) > MAX_ROWS - 2) begin
         last_row = ROW_W'(MAX_ROWS - 1);
      end else begin
         last_row = ROW_W'(32'(interior_rows_ff) + 32'd1);
      end
   end

   // ------------------------------------------------------------------
   // Input stage: raster position and line buffer read
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in, cur_col;
   logic [ROW_W-1:0] row_ff, row_in, cur_row;
   logic             at_end;
   logic             req_xfer;
   logic             s1_valid_ff;
   logic [Q_CW-1:0]  q_count_ff;

   assign cur_col  = ({1'b0, col_ff} >= eff_width) ? last_col : col_ff;
   assign cur_row  = (row_ff > last_row) ? last_row : row_ff;
   assign at_end   = (cur_col == last_col);
   assign req_xfer = req_if.valid & req_if.ready;

   // Take a cell only when the queue can hold every result still owed
   always_comb begin
      if (reset) begin
         req_if.ready = 1'b0;
      end else if (s1_valid_ff) begin
         req_if.ready = (q_count_ff <= Q_CW'(Q_OPEN_BUSY));
      end else begin
         req_if.ready = (q_count_ff <= Q_CW'(Q_OPEN_IDLE));
      end
   end

   // Advance the raster position; wrap the row at its last column
   always_comb begin
      if (at_end) begin
         col_in = '0;
         row_in = (cur_row >= last_row) ? '0 : cur_row + ROW_W'(1);
      end else begin
         col_in = cur_col + COL_W'(1);
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line buffer: per column, bit 1 holds the previous row, bit 0 the one before
   logic [1:0]       row_buf_ff [MAX_COLS];
   logic [1:0]       rd_data_ff;
   logic             s1_cell_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_end_ff;
   logic             s1_live_ff;
   logic             s1_last_ff;

   // Read the column on transfer; write it back shifted one row in the next cycle
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_data_ff <= row_buf_ff[cur_col];
      end
      if (s1_valid_ff) begin
         row_buf_ff[s1_col_ff] <= {s1_cell_ff, rd_data_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cell_ff <= req_if.cell_in;
         s1_col_ff  <= cur_col;
         s1_row_ff  <= cur_row;
         s1_end_ff  <= at_end;
         s1_live_ff <= (cur_row >= ROW_W'(FIRST_LIVE_ROW)) &&
                       (cur_col >= COL_W'(FIRST_LIVE_COL));
         s1_last_ff <= (cur_row == last_row);
      end
   end

   // ------------------------------------------------------------------
   // Window stage: 3x3 neighborhood and rule evaluation
   // ------------------------------------------------------------------
   col_vec_type     cur_vec;
   col_vec_type     win1_ff, win2_ff, col0_ff, col1_ff;
   result_type      res [BURST_MAX];
   logic [PUSH_W-1:0] n_push;
   logic [ROW_OUT_W-1:0] res_row;

   assign cur_vec = {s1_cell_ff, rd_data_ff};

   // Shift the window; keep the first two columns for the wrap at row end
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win1_ff <= cur_vec;
         win2_ff <= win1_ff;
         if (s1_col_ff == COL_W'(0)) begin
            col0_ff <= cur_vec;
         end
         if (s1_col_ff == COL_W'(1)) begin
            col1_ff <= cur_vec;
         end
      end
   end

   assign res_row = ROW_OUT_W'(s1_row_ff - ROW_W'(FIRST_LIVE_ROW));

   // Cell left of the arrival, then last column and column zero at row end
   always_comb begin
      res[0].out_row   = res_row;
      res[0].out_col   = COL_OUT_W'(s1_col_ff - COL_W'(1));
      res[0].cell_next = life_next(win2_ff, win1_ff, cur_vec);
      res[0].gen_last  = 1'b0;
      res[1].out_row   = res_row;
      res[1].out_col   = COL_OUT_W'(s1_col_ff);
      res[1].cell_next = life_next(win1_ff, cur_vec, col0_ff);
      res[1].gen_last  = 1'b0;
      res[2].out_row   = res_row;
      res[2].out_col   = '0;
      res[2].cell_next = life_next(cur_vec, col0_ff, col1_ff);
      res[2].gen_last  = s1_last_ff;
   end

   always_comb begin
      if (s1_valid_ff && s1_live_ff) begin
         n_push = s1_end_ff ? PUSH_W'(BURST_MAX) : PUSH_W'(1);
      end else begin
         n_push = '0;
      end
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   result_type      rsp_q_ff [RSP_QUEUE_DEPTH];
   result_type      head;
   logic [Q_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic            rsp_xfer;

   assign rsp_xfer = rsp_if.valid & rsp_if.ready;

   // Push up to three results into consecutive slots
   always_ff @(posedge clock) begin
      for (int k = 0; k < BURST_MAX; k++) begin
         if (PUSH_W'(k) < n_push) begin
            rsp_q_ff[wr_ptr_ff + Q_AW'(k)] <= res[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_ff + Q_AW'(n_push);
         rd_ptr_ff  <= rd_ptr_ff + Q_AW'(rsp_xfer);
         q_count_ff <= q_count_ff + Q_CW'(n_push) - Q_CW'(rsp_xfer);
      end
   end

   // Offer the head of the queue
   assign head             = rsp_q_ff[rd_ptr_ff];
   assign rsp_if.valid     = (q_count_ff != '0);
   assign rsp_if.out_row   = head.out_row;
   assign rsp_if.out_col   = head.out_col;
   assign rsp_if.cell_next = head.cell_next;
   assign rsp_if.gen_last  = head.gen_last;

endmodule

`default_nettype wire

FILE: hw/rtl/lgs_checker.sv
// Port-level assertions for the life stencil top level, bound to it below.
// Depends on lgs_pkg and life_generation_stencil_top_defines.svh.
`default_nettype none

`include "life_generation_stencil_top_defines.svh"

module lgs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lgs_pkg::ROW_OUT_W-1:0] out_row,
   input logic [lgs_pkg::COL_OUT_W-1:0] out_col,
   input logic                          cell_next,
   input logic                          gen_last
);
   import lgs_pkg::*;

   // No cell is taken while reset is applied
   `LGS_CHECK_ANY(a_no_take_in_reset, reset, !req_ready, "cell taken during reset")

   // Reset empties the result queue
   `LGS_CHECK_ANY(a_empty_after_reset, $past(reset), !rsp_valid, "result offered after reset")

   // A stalled result stays offered
   `LGS_CHECK_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // A stalled result keeps its payload
   `LGS_CHECK_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(out_row) && $stable(out_col) && $stable(cell_next) && $stable(gen_last), "result changed while stalled")

   // The slab closes on the wrapped column zero result
   `LGS_CHECK_IMP(a_last_at_col0, rsp_valid && gen_last, out_col == '0, "slab end not on column zero")

endmodule

bind life_generation_stencil_top lgs_checker u_lgs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .out_row   (rsp_if.out_row),
   .out_col   (rsp_if.out_col),
   .cell_next (rsp_if.cell_next),
   .gen_last  (rsp_if.gen_last)
);

`default_nettype wire

FILE: tb/stencil_result_check.sv
`timescale 1ns / 1ps
// Result checker for the life stencil block: tracks register writes and cell transfers,
// predicts each B3/S23 update and compares it with what the block delivers.
// Depends on lgs_pkg and the channel interfaces in lgs_stream_if.
module stencil_result_check
   import lgs_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   lgs_req_if                    req_if,
   lgs_rsp_if                    rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending_results
);

   // Three buffered rows, the geometry registers and the slab position
   bit [MAX_COLS-1:0]      ring_rows [3];
   logic [ROW_WIDTH_W-1:0] width_reg;
   logic [INT_ROWS_W-1:0]  rows_reg;
   int unsigned            row_pos;
   int unsigned            col_pos;
   int unsigned            top_slot;
   result_type             due_cells [$];

   // Next state of the middle buffered row's cell at column c
   function automatic logic next_gen(input int unsigned top, input int unsigned c,
                                     input int unsigned w);
      int unsigned mid, old, cl, cr, n;
      mid = (top + 2) % 3;
      old = (top + 1) % 3;
      cl  = (c == 0) ? w - 1 : c - 1;
      cr  = (c + 1 >= w) ? 0 : c + 1;
      n   = ring_rows[old][cl] + ring_rows[old][c] + ring_rows[old][cr]
          + ring_rows[mid][cl] + ring_rows[mid][cr]
          + ring_rows[top][cl] + ring_rows[top][c] + ring_rows[top][cr];
      return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && ring_rows[mid][c]);
   endfunction

   task automatic push_due(input int unsigned row, input int unsigned col, input logic val,
                           input logic last);
      result_type item;
      item.out_row   = row[ROW_OUT_W-1:0];
      item.out_col   = col[COL_OUT_W-1:0];
      item.cell_next = val;
      item.gen_last  = last;
      due_cells.push_back(item);
   endtask

   // Store one incoming cell and queue the updates it completes
   task automatic take_cell(input logic cell_bit);
      int unsigned w, rr, c, r, top;
      w = width_reg;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_COLS) w = MAX_COLS;
      rr = rows_reg;
      if (rr < MIN_INT_ROWS) rr = MIN_INT_ROWS;
      if (rr > MAX_ROWS - 2) rr = MAX_ROWS - 2;
      c   = col_pos;
      r   = row_pos;
      top = top_slot % 3;
      if (c >= w) c = w - 1;
      if (r > rr + 1) r = rr + 1;

      ring_rows[top][c] = cell_bit;

      // The top halo row and the first interior row produce nothing
      if (r >= FIRST_LIVE_ROW) begin
         if (c >= FIRST_LIVE_COL) push_due(r - 2, c - 1, next_gen(top, c - 1, w), 1'b0);
         if (c == w - 1) begin
            push_due(r - 2, w - 1, next_gen(top, w - 1, w), 1'b0);
            push_due(r - 2, 0, next_gen(top, 0, w), r == rr + 1);
         end
      end

      // Advance the raster position, wrapping to a new slab after the bottom halo
      if (c == w - 1) begin
         col_pos = 0;
         if (r >= rr + 1) begin
            row_pos  = 0;
            top_slot = 0;
         end else begin
            row_pos  = r + 1;
            top_slot = (top + 1) % 3;
         end
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   always @(posedge clock) begin
      logic [CSR_IDX_W-1:0] idx;
      result_type           want;
      if (reset) begin
         width_reg  = ROW_WIDTH_RST;
         rows_reg   = INT_ROWS_RST;
         row_pos    = 0;
         col_pos    = 0;
         top_slot   = 0;
         fail_count = 0;
         due_cells.delete();
      end else begin
         // Compare each result transfer with the oldest prediction
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_cells.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with nothing due: row %0d col %0d next %0b last %0b",
                           $realtime, rsp_if.out_row, rsp_if.out_col, rsp_if.cell_next,
                           rsp_if.gen_last);
            end else begin
               want = due_cells.pop_front();
               if (rsp_if.out_row !== want.out_row || rsp_if.out_col !== want.out_col ||
                   rsp_if.cell_next !== want.cell_next || rsp_if.gen_last !== want.gen_last)
               begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: cell mismatch: expected row %0d col %0d next %0b last %0b,",
                               " got row %0d col %0d next %0b last %0b"},
                              $realtime, want.out_row, want.out_col, want.cell_next,
                              want.gen_last, rsp_if.out_row, rsp_if.out_col,
                              rsp_if.cell_next, rsp_if.gen_last);
               end
            end
         end

         // Register write: update the geometry and restart the slab
         if (psel && penable && pwrite && pready) begin
            idx = paddr[CSR_ADDR_W-1:2];
            if (idx == REG_ROW_WIDTH || idx == REG_INTERIOR_ROWS) begin
               if (idx == REG_ROW_WIDTH) width_reg = pwdata[ROW_WIDTH_W-1:0];
               else rows_reg = pwdata[INT_ROWS_W-1:0];
               row_pos  = 0;
               col_pos  = 0;
               top_slot = 0;
            end
         end

         if (req_if.valid && req_if.ready) take_cell(req_if.cell_in);
      end
      pending_results = due_cells.size();
   end

endmodule

FILE: tb/life_generation_stencil_top_tb.sv
`timescale 1ns / 1ps
// Top of the life stencil testbench: clock, reset, register writes, cell stimulus and
// result back-pressure. Instantiates life_generation_stencil_top and stencil_result_check.
module life_generation_stencil_top_tb;
   import lgs_pkg::*;

   localparam int RESET_CELLS  = 2 * ROW_WIDTH_RST + 10;
   localparam int WIDE_CELLS   = 20;
   localparam int TALL_CELLS   = 30;
   localparam int RANDOM_CELLS = 110;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 200;
   localparam int IDLE_MAX     = 11;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic                  pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   int                    fail_count;
   int                    pending_results;
   int                    stall_cycles;
   bit                    tx_idle_on;
   bit                    rx_idle_on;
   bit                    hold_request;
   bit                    rsp_hold;
   int unsigned           cur_width;
   int unsigned           cur_rows;

   lgs_req_if req_if ();
   lgs_rsp_if rsp_if ();

   always #5 clock = ~clock;

   life_generation_stencil_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   stencil_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   function automatic int pick_gap(input bit on);
      return on ? int'($urandom_range(IDLE_MAX, 0)) : 0;
   endfunction

   // Cells in one full slab under the current geometry
   function automatic int slab_cells();
      int unsigned w, r;
      w = cur_width;
      r = cur_rows;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_COLS_DEF) w = MAX_COLS_DEF;
      if (r < MIN_INT_ROWS) r = MIN_INT_ROWS;
      if (r > MAX_ROWS_DEF - 2) r = MAX_ROWS_DEF - 2;
      return w * (r + 2);
   endfunction

   // Setup and access phase of one register write; returns after psel drops
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      if (idx == REG_ROW_WIDTH) cur_width = value[ROW_WIDTH_W-1:0];
      else cur_rows = value[INT_ROWS_W-1:0];
   endtask

   // Offer one cell after a random gap and hold it until the transfer
   task automatic send_cell(input logic cell_bit);
      int gap;
      gap = pick_gap(tx_idle_on);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cell_in <= cell_bit;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic send_random(input int count, input int unsigned alive_pct);
      repeat (count) send_cell($urandom_range(99, 0) < alive_pct);
   endtask

   // Drop valid and wait until every predicted result is out and the pipe is empty
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Result side: random gap after each transfer, forced low during a hold-off
   initial begin : rsp_side
      int gap;
      bit took;
      rsp_if.ready = 1'b0;
      gap = 0;
      forever begin
         @(posedge clock);
         took = rsp_if.valid && rsp_if.ready;
         @(negedge clock);
         if (took) gap = pick_gap(rx_idle_on);
         if (reset || rsp_hold) begin
            rsp_if.ready <= 1'b0;
         end else if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            gap--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off so the result queue fills and the input stalls
   initial begin : rsp_hold_off
      rsp_hold = 1'b0;
      wait (hold_request);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      logic [8:0]            patterns [2];
      logic [CSR_DATA_W-1:0] width_val;
      logic [CSR_DATA_W-1:0] rows_val;
      int                    random_cells;
      int                    slabs;
      int                    cells;
      int unsigned           alive_pct;
      bit                    first_phase;

      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_if.valid   = 1'b0;
      req_if.cell_in = 1'b0;
      tx_idle_on     = 1'b1;
      rx_idle_on     = 1'b1;
      hold_request   = 1'b0;
      stall_cycles   = 0;
      cur_width      = ROW_WIDTH_RST;
      cur_rows       = INT_ROWS_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Reset geometry: run past the top halo row into the second interior row
      send_random(RESET_CELLS, 50);
      settle();

      // Smallest torus: a dense slab that dies out and a vertical blinker
      patterns[0] = 9'b111_111_111;
      patterns[1] = 9'b010_010_010;
      csr_write(REG_ROW_WIDTH, 3);
      csr_write(REG_INTERIOR_ROWS, 1);
      foreach (patterns[p])
         for (int i = 8; i >= 0; i--) send_cell(patterns[p][i]);
      settle();

      // Zero width and zero rows clamp up; leave the second slab unfinished
      csr_write(REG_ROW_WIDTH, 0);
      csr_write(REG_INTERIOR_ROWS, 0);
      send_random(9, 50);
      send_random(5, 50);
      settle();

      // Width above the limit clamps down; stream part of the halo row without idling
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      csr_write(REG_ROW_WIDTH, (1 << ROW_WIDTH_W) - 1);
      send_random(WIDE_CELLS, 30);
      settle();

      // Narrowest row, row count above the limit: run into the interior rows
      tx_idle_on = 1'b1;
      csr_write(REG_ROW_WIDTH, MIN_WIDTH);
      csr_write(REG_INTERIOR_ROWS, (1 << INT_ROWS_W) - 1);
      send_random(TALL_CELLS, 40);
      settle();

      // Random small geometries, whole slabs with the odd slab cut short
      random_cells = 0;
      first_phase  = 1'b1;
      while (random_cells < RANDOM_CELLS) begin
         width_val = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(10, 3);
         rows_val  = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(5, 1);
         if ($urandom_range(3, 0) == 0) width_val = width_val | ($urandom << ROW_WIDTH_W);
         if ($urandom_range(3, 0) == 0) rows_val = rows_val | ($urandom << INT_ROWS_W);
         tx_idle_on = ($urandom_range(3, 0) != 0);
         rx_idle_on = ($urandom_range(3, 0) != 0);
         slabs      = $urandom_range(3, 1);
         alive_pct  = $urandom_range(80, 15);
         if (first_phase) begin
            // Receiver holds off while the sender keeps pushing
            width_val    = 8;
            rows_val     = 4;
            slabs        = 1;
            tx_idle_on   = 1'b0;
            hold_request = 1'b1;
            first_phase  = 1'b0;
            csr_write(REG_ROW_WIDTH, width_val);
            csr_write(REG_INTERIOR_ROWS, rows_val);
         end else begin
            case ($urandom_range(3, 0))
               0: csr_write(REG_ROW_WIDTH, width_val);
               1: csr_write(REG_INTERIOR_ROWS, rows_val);
               2: begin
                  csr_write(REG_INTERIOR_ROWS, rows_val);
                  csr_write(REG_ROW_WIDTH, width_val);
               end
               default: begin
                  csr_write(REG_ROW_WIDTH, width_val);
                  csr_write(REG_INTERIOR_ROWS, rows_val);
               end
            endcase
         end
         cells = slabs * slab_cells();
         if ($urandom_range(3, 0) == 0) cells += $urandom_range(slab_cells() - 1, 1);
         // Keep the whole run near its item budget
         if (cells > RANDOM_CELLS - random_cells) cells = RANDOM_CELLS - random_cells;
         send_random(cells, alive_pct);
         random_cells += cells;
         settle();
      end

      if (fail_count == 0 && pending_results == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_stream_if.sv
hw/rtl/life_generation_stencil_top.sv
hw/rtl/lgs_checker.sv
tb/stencil_result_check.sv
tb/life_generation_stencil_top_tb.sv
